[hw/rtl/point_in_triangle_search_core_defines.svh]
// ----------------------------------------------------------------------------
// Point-in-triangle search core: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_TRIANGLE_SEARCH_CORE_DEFINES_SVH
`define POINT_IN_TRIANGLE_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PITS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pits assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PITS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pits assertion failed");

`endif

[hw/rtl/pits_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-triangle search package
// Beat types, vertex record, arithmetic widths and the weight sign test.
// ----------------------------------------------------------------------------
package pits_pkg;

  localparam int CoordBits = 24;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int DetBits   = ProdBits + 1;
  localparam int WbBits    = DetBits + 2;
  localparam int SlotBits  = 10;
  localparam int CountBits = 11;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [DetBits-1:0]   det_t;
  typedef logic signed [WbBits-1:0]    wb_t;

  typedef struct packed {
    logic                        func;
    logic [SlotBits-1:0]         slot;
    logic signed [CoordBits-1:0] first_x;
    logic signed [CoordBits-1:0] first_y;
    logic signed [CoordBits-1:0] second_x;
    logic signed [CoordBits-1:0] second_y;
    logic signed [CoordBits-1:0] third_x;
    logic signed [CoordBits-1:0] third_y;
    logic signed [CoordBits-1:0] query_x;
    logic signed [CoordBits-1:0] query_y;
  } pits_cmd_t;

  typedef struct packed {
    logic                found;
    logic [SlotBits-1:0] triangle_index;
  } pits_result_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
  } tri_t;

  // Control for one pass through the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;
    logic first;
    logic neg;
    logic last;
  } mac_ctl_t;

  function automatic diff_t sub_coord(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  // A weight passes when it is zero or carries the sign of the determinant.
  function automatic logic weight_ok(wb_t w, logic det_neg);
    return (w == '0) || (w[WbBits-1] == det_neg);
  endfunction

endpackage

[hw/rtl/pits_vertex_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle vertex store
// One write port and one registered read port over the triangle table.
// ----------------------------------------------------------------------------
module pits_vertex_store #(
  parameter int unsigned Depth = 1024,
  parameter int          AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  pits_pkg::tri_t      wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output pits_pkg::tri_t      rdata_o
);

  pits_pkg::tri_t mem_q [Depth];
  pits_pkg::tri_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pits_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registered signed product, then accumulate or restart; flags the last pass.
// ----------------------------------------------------------------------------
module pits_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pits_pkg::mac_ctl_t  ctl_i,
  input  pits_pkg::diff_t     opa_i,
  input  pits_pkg::diff_t     opb_i,
  output logic                res_valid_o,
  output pits_pkg::det_t      res_o
);

  pits_pkg::prod_t    prod_q;
  pits_pkg::mac_ctl_t ctl_q;
  pits_pkg::det_t     acc_q, acc_d, term;
  logic               res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      ctl_q       <= ctl_i;
      res_valid_q <= ctl_q.en && ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      prod_q <= opa_i * opb_i;
    end
    if (ctl_q.en) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    term  = pits_pkg::det_t'(prod_q);
    acc_d = ctl_q.first ? '0 : acc_q;
    if (ctl_q.neg) begin
      acc_d = acc_d - term;
    end else begin
      acc_d = acc_d + term;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = acc_q;

endmodule

[hw/rtl/point_in_triangle_search_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-triangle search core
// Triangle table with an exact, division-free barycentric point search.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd_i and raise start; a beat is taken at a rising
//   edge with start high and busy low. func selects load or query.
//   A load writes the three vertices into the named slot (slots at or past
//   the table depth store nothing) and answers in the next cycle with
//   found = 0 and triangle_index = slot. Loads can issue every cycle while idle.
//   A query walks slots 0 to min(triangle_count, depth) - 1 and answers with
//   the first slot containing the point, or found = 0 and index 0 on a miss.
//   Each slot steps through fetch, operand prep, six passes through the
//   one shared 25x25 multiplier, a drain of its pipeline, then the third
//   weight and the sign test. busy stays high for the whole walk; one query
//   is in flight at a time.
//   Results: done_o pulses for exactly one cycle with result_o; the receiver
//   cannot stall, so the beat is taken at the edge ending that cycle.
//   Config: cfg_we_i writes triangle_count; the user must write it only while
//   the core is idle; the core does not enforce it. Reset clears the count and
//   the sequencer; the table is undefined until loaded; no clearing pass runs.
// ----------------------------------------------------------------------------
`include "point_in_triangle_search_core_defines.svh"

module point_in_triangle_search_core #(
  parameter int unsigned MAX_TRIANGLES = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  pits_pkg::pits_cmd_t                  cmd_i,
  output logic                                 done_o,
  output pits_pkg::pits_result_t               result_o,
  input  logic                                 cfg_we_i,
  input  logic [pits_pkg::CountBits-1:0]       cfg_wdata_i
);

  localparam int IdxW  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CntW  = $clog2(MAX_TRIANGLES + 1);
  localparam int SlotW = pits_pkg::SlotBits;

  // Sequencer codes.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIFF  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;
  localparam logic [2:0] S_TEST  = 3'd6;

  localparam logic [2:0] LastStep = 3'd5;
  localparam logic [1:0] LastCap  = 2'd2;

  logic [2:0]                    state_q, state_d;
  logic [CntW-1:0]               scan_q, scan_d;
  logic [2:0]                    step_q, step_d;
  logic [1:0]                    cap_q, cap_d;
  logic [pits_pkg::CountBits-1:0] count_q;
  logic [CntW-1:0]               limit;
  logic                          done_q, done_d;
  pits_pkg::pits_result_t        result_q, result_d;

  logic accept, accept_load, accept_query, slot_ok, hit;

  pits_pkg::coord_t   px_q, py_q;
  pits_pkg::tri_t     wr_tri, rd_tri;
  logic               rd_en;
  pits_pkg::diff_t    ux_q, uy_q, vx_q, vy_q;
  pits_pkg::diff_t    bpx_q, bpy_q, cpx_q, cpy_q, pax_q, pay_q;
  pits_pkg::diff_t    opa, opb;
  pits_pkg::mac_ctl_t mac_ctl;
  logic               mac_valid;
  pits_pkg::det_t     mac_res;
  pits_pkg::det_t     d_q, wa_q, wc_q;
  pits_pkg::wb_t      wb_q;

  assign busy         = (state_q != S_IDLE);
  assign accept       = start && !busy;
  assign accept_load  = accept && (cmd_i.func == pits_pkg::FuncLoad);
  assign accept_query = accept && (cmd_i.func == pits_pkg::FuncQuery);
  assign slot_ok      = (32'(cmd_i.slot) < 32'(MAX_TRIANGLES));

  // Clamp the walk length to the table depth.
  always_comb begin
    if (32'(count_q) > 32'(MAX_TRIANGLES)) begin
      limit = CntW'(MAX_TRIANGLES);
    end else begin
      limit = CntW'(count_q);
    end
  end

  assign wr_tri = '{ax: cmd_i.first_x,  ay: cmd_i.first_y,
                    bx: cmd_i.second_x, by: cmd_i.second_y,
                    cx: cmd_i.third_x,  cy: cmd_i.third_y};

  pits_vertex_store #(
    .Depth(MAX_TRIANGLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (accept_load && slot_ok),
    .waddr_i(IdxW'(cmd_i.slot)),
    .wdata_i(wr_tri),
    .re_i   (rd_en),
    .raddr_i(scan_q[IdxW-1:0]),
    .rdata_o(rd_tri)
  );

  pits_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mac_ctl),
    .opa_i      (opa),
    .opb_i      (opb),
    .res_valid_o(mac_valid),
    .res_o      (mac_res)
  );

  // Inside test: nonzero determinant and all three weights agree with it.
  assign hit = (d_q != '0)
            && pits_pkg::weight_ok(pits_pkg::wb_t'(wa_q), d_q[pits_pkg::DetBits-1])
            && pits_pkg::weight_ok(wb_q, d_q[pits_pkg::DetBits-1])
            && pits_pkg::weight_ok(pits_pkg::wb_t'(wc_q), d_q[pits_pkg::DetBits-1]);

  // Operand select for the six passes: D from (u, v), wa from (B-P, C-P),
  // wc from (u, P-A); odd passes subtract and close a determinant.
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (step_q)
      3'd0: begin
        opa = ux_q;
        opb = vy_q;
      end
      3'd1: begin
        opa = uy_q;
        opb = vx_q;
      end
      3'd2: begin
        opa = bpx_q;
        opb = cpy_q;
      end
      3'd3: begin
        opa = bpy_q;
        opb = cpx_q;
      end
      3'd4: begin
        opa = ux_q;
        opb = pay_q;
      end
      3'd5: begin
        opa = uy_q;
        opb = pax_q;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    scan_d   = scan_q;
    step_d   = step_q;
    cap_d    = cap_q;
    done_d   = 1'b0;
    result_d = result_q;
    rd_en    = 1'b0;
    mac_ctl  = '0;

    // Count finished determinants as they leave the unit.
    if (mac_valid) begin
      cap_d = cap_q + 2'd1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept_query) begin
          scan_d  = '0;
          state_d = S_CHECK;
        end else if (accept_load) begin
          done_d                  = 1'b1;
          result_d.found          = 1'b0;
          result_d.triangle_index = cmd_i.slot;
        end
      end
      S_CHECK: begin
        if (scan_q == limit) begin
          // Walk over without a hit: report a miss.
          done_d   = 1'b1;
          result_d = '0;
          state_d  = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        step_d  = '0;
        cap_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.first = !step_q[0];
        mac_ctl.neg   = step_q[0];
        mac_ctl.last  = step_q[0];
        if (step_q == LastStep) begin
          state_d = S_DRAIN;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_DRAIN: begin
        if (mac_valid && (cap_q == LastCap)) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        state_d = S_TEST;
      end
      S_TEST: begin
        if (hit) begin
          done_d                  = 1'b1;
          result_d.found          = 1'b1;
          result_d.triangle_index = SlotW'(scan_q);
          state_d                 = S_IDLE;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      scan_q   <= '0;
      step_q   <= '0;
      cap_q    <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      step_q   <= step_d;
      cap_q    <= cap_d;
      done_q   <= done_d;
      result_q <= result_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers: query point, edge vectors, determinants.
  always_ff @(posedge clk_i) begin
    if (accept_query) begin
      px_q <= cmd_i.query_x;
      py_q <= cmd_i.query_y;
    end
    if (state_q == S_DIFF) begin
      ux_q  <= pits_pkg::sub_coord(rd_tri.bx, rd_tri.ax);
      uy_q  <= pits_pkg::sub_coord(rd_tri.by, rd_tri.ay);
      vx_q  <= pits_pkg::sub_coord(rd_tri.cx, rd_tri.ax);
      vy_q  <= pits_pkg::sub_coord(rd_tri.cy, rd_tri.ay);
      bpx_q <= pits_pkg::sub_coord(rd_tri.bx, px_q);
      bpy_q <= pits_pkg::sub_coord(rd_tri.by, py_q);
      cpx_q <= pits_pkg::sub_coord(rd_tri.cx, px_q);
      cpy_q <= pits_pkg::sub_coord(rd_tri.cy, py_q);
      pax_q <= pits_pkg::sub_coord(px_q, rd_tri.ax);
      pay_q <= pits_pkg::sub_coord(py_q, rd_tri.ay);
    end
    if (mac_valid) begin
      case (cap_q)
        2'd0:    d_q  <= mac_res;
        2'd1:    wa_q <= mac_res;
        default: wc_q <= mac_res;
      endcase
    end
    if (state_q == S_WB) begin
      wb_q <= pits_pkg::wb_t'(d_q) - pits_pkg::wb_t'(wa_q) - pits_pkg::wb_t'(wc_q);
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // A result beat follows either a load beat or a cycle of walking.
  `PITS_ASSERT_IMP(a_done_source, clk_i, rst_ni, done_o, $past(busy) || $past(accept_load))
  // A hit never names a slot outside the searched range.
  `PITS_ASSERT_IMP(a_hit_in_range, clk_i, rst_ni, done_o && result_o.found, scan_q < limit)
  // The unit hands back at most three determinants per slot.
  `PITS_ASSERT_IMP(a_cap_bound, clk_i, rst_ni, mac_valid, cap_q <= LastCap)
  // A query beat always starts a walk.
  `PITS_ASSERT_NXT(a_query_busy, clk_i, rst_ni, accept_query, busy)

endmodule

[verif/tb_point_in_triangle_search_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-triangle search core testbench
// Drives load and query beats through the start/busy handshake with random
// gaps, predicts every answer with an exact 64-bit barycentric sign test over
// a private copy of the triangle table, and checks each done_o beat against
// the oldest prediction. Walks small tables for most queries, and runs a few
// queries with the count at the depth and at the register maximum on points
// that a loaded slot is known to contain.
// ----------------------------------------------------------------------------
module tb_point_in_triangle_search_core;

  localparam int unsigned TableDepth    = 1024;
  localparam int unsigned FilledSlots   = 32;
  localparam int unsigned RandomPhases  = 16;
  localparam int unsigned PhaseItems    = 33;
  localparam int unsigned LongQueries   = 3;
  localparam int unsigned WatchdogLimit = 50000;
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned CountMax      = (1 << pits_pkg::CountBits) - 1;
  localparam int          CoordMax      = 8388607;
  localparam int          CoordMin      = -8388608;
  localparam int          Half          = 4194304;

  typedef struct packed {
    pits_pkg::coord_t x;
    pits_pkg::coord_t y;
  } pt_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           start       = 1'b0;
  logic                           busy;
  pits_pkg::pits_cmd_t            cmd_i       = '0;
  logic                           done_o;
  pits_pkg::pits_result_t         result_o;
  logic                           cfg_we_i    = 1'b0;
  logic [pits_pkg::CountBits-1:0] cfg_wdata_i = '0;

  // Beats waiting to be driven, and answers waiting for done_o.
  pits_pkg::pits_cmd_t    cmd_q[$];
  pits_pkg::pits_result_t answer_q[$];

  // Predictor state: triangle table and search count as the block sees them.
  pits_pkg::tri_t                 tri_table [TableDepth];
  logic [pits_pkg::CountBits-1:0] tri_count_model = '0;
  // Stimulus view of the table, ahead of the predictor by the queued loads.
  pits_pkg::tri_t                 plan_table [TableDepth];

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  int unsigned gap_left       = 0;
  int unsigned steady_left    = 0;

  always #10 clk_i = ~clk_i;

  point_in_triangle_search_core #(
    .MAX_TRIANGLES(TableDepth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // A weight passes when it is zero or has the sign of the determinant.
  function automatic bit weight_agrees(longint w, longint d);
    return (w == 0) || ((w < 0) == (d < 0));
  endfunction

  // Exact point-in-triangle test; every term fits comfortably in 64 bits.
  function automatic bit contains(pits_pkg::tri_t t, pits_pkg::coord_t px,
                                  pits_pkg::coord_t py);
    longint ax, ay, bx, by, cx, cy, qx, qy, d, wa, wb, wc;
    ax = longint'($signed(t.ax));
    ay = longint'($signed(t.ay));
    bx = longint'($signed(t.bx));
    by = longint'($signed(t.by));
    cx = longint'($signed(t.cx));
    cy = longint'($signed(t.cy));
    qx = longint'($signed(px));
    qy = longint'($signed(py));
    d  = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    wa = (bx - qx) * (cy - qy) - (by - qy) * (cx - qx);
    wc = (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
    wb = d - wa - wc;
    // A degenerate triangle never matches.
    if (d == 0) return 1'b0;
    return weight_agrees(wa, d) && weight_agrees(wb, d) && weight_agrees(wc, d);
  endfunction

  // Apply one accepted beat to the predictor and return its answer.
  function automatic pits_pkg::pits_result_t resolve_cmd(pits_pkg::pits_cmd_t c);
    pits_pkg::pits_result_t r;
    int unsigned            n;
    int unsigned            i;
    r = '0;
    if (c.func == pits_pkg::FuncLoad) begin
      tri_table[c.slot].ax = c.first_x;
      tri_table[c.slot].ay = c.first_y;
      tri_table[c.slot].bx = c.second_x;
      tri_table[c.slot].by = c.second_y;
      tri_table[c.slot].cx = c.third_x;
      tri_table[c.slot].cy = c.third_y;
      r.triangle_index = c.slot;
    end else begin
      // Clamp the walk to the table depth.
      n = (tri_count_model > TableDepth) ? TableDepth : tri_count_model;
      for (i = 0; i < n; i++) begin
        if (contains(tri_table[i], c.query_x, c.query_y)) begin
          r.found          = 1'b1;
          r.triangle_index = i[pits_pkg::SlotBits-1:0];
          return r;
        end
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic pits_pkg::coord_t rand_coord();
    return pits_pkg::coord_t'($urandom);
  endfunction

  function automatic int jitter(int unsigned s);
    return int'($urandom_range(0, 2 * s)) - int'(s);
  endfunction

  function automatic pt_t pt_of(int x, int y);
    pt_t p;
    p.x = pits_pkg::coord_t'(x);
    p.y = pits_pkg::coord_t'(y);
    return p;
  endfunction

  // Fill every field but func with noise; the unused ones must be ignored.
  function automatic pits_pkg::pits_cmd_t random_cmd();
    pits_pkg::pits_cmd_t c;
    c.func     = pits_pkg::FuncLoad;
    c.slot     = pits_pkg::SlotBits'($urandom);
    c.first_x  = rand_coord();
    c.first_y  = rand_coord();
    c.second_x = rand_coord();
    c.second_y = rand_coord();
    c.third_x  = rand_coord();
    c.third_y  = rand_coord();
    c.query_x  = rand_coord();
    c.query_y  = rand_coord();
    return c;
  endfunction

  function automatic pits_pkg::tri_t tri_of(int ax, int ay, int bx, int by, int cx,
                                            int cy);
    pits_pkg::tri_t t;
    t.ax = pits_pkg::coord_t'(ax);
    t.ay = pits_pkg::coord_t'(ay);
    t.bx = pits_pkg::coord_t'(bx);
    t.by = pits_pkg::coord_t'(by);
    t.cx = pits_pkg::coord_t'(cx);
    t.cy = pits_pkg::coord_t'(cy);
    return t;
  endfunction

  // Mix of full-range, axis-aligned, collinear, single-point and general
  // triangles; max_shift bounds the size of the local ones.
  function automatic pits_pkg::tri_t random_tri(int unsigned max_shift);
    pits_pkg::tri_t t;
    int             ox, oy;
    int unsigned    s, mode;
    mode = $urandom_range(0, 99);
    if (max_shift > 20 && mode < 25) begin
      t.ax = rand_coord();
      t.ay = rand_coord();
      t.bx = rand_coord();
      t.by = rand_coord();
      t.cx = rand_coord();
      t.cy = rand_coord();
      return t;
    end
    s    = 1 << $urandom_range(2, (max_shift > 20) ? 20 : max_shift);
    ox   = int'($urandom_range(0, 2 * Half)) - Half;
    oy   = int'($urandom_range(0, 2 * Half)) - Half;
    t.ax = pits_pkg::coord_t'(ox + jitter(s));
    t.ay = pits_pkg::coord_t'(oy + jitter(s));
    if (mode < 45) begin
      // Right angle at A, legs on the axes.
      t.bx = t.ax + pits_pkg::coord_t'(jitter(s));
      t.by = t.ay;
      t.cx = t.ax;
      t.cy = t.ay + pits_pkg::coord_t'(jitter(s));
    end else if (mode < 55) begin
      // Collinear: C continues the line from A through B.
      t.bx = t.ax + pits_pkg::coord_t'(jitter(s));
      t.by = t.ay + pits_pkg::coord_t'(jitter(s));
      t.cx = t.bx + (t.bx - t.ax);
      t.cy = t.by + (t.by - t.ay);
    end else if (mode < 60) begin
      t.bx = t.ax;
      t.by = t.ay;
      t.cx = t.ax;
      t.cy = t.ay;
    end else begin
      t.bx = pits_pkg::coord_t'(ox + jitter(s));
      t.by = pits_pkg::coord_t'(oy + jitter(s));
      t.cx = pits_pkg::coord_t'(ox + jitter(s));
      t.cy = pits_pkg::coord_t'(oy + jitter(s));
    end
    return t;
  endfunction

  // Pick a vertex, an edge point or an interior point of a triangle.
  function automatic pt_t point_on(pits_pkg::tri_t t);
    pt_t         p;
    longint      w1, w2, w3;
    int unsigned mode, k;
    mode = $urandom_range(0, 3);
    k    = $urandom_range(0, 2);
    w1   = $urandom_range(1, 9);
    w2   = $urandom_range(1, 9);
    w3   = $urandom_range(1, 9);
    if (mode == 0) begin
      w1 = (k == 0) ? 1 : 0;
      w2 = (k == 1) ? 1 : 0;
      w3 = (k == 2) ? 1 : 0;
    end else if (mode == 1) begin
      if (k == 0) w1 = 0;
      else if (k == 1) w2 = 0;
      else w3 = 0;
    end
    p.x = pits_pkg::coord_t'((w1 * longint'($signed(t.ax)) + w2 * longint'($signed(t.bx))
                              + w3 * longint'($signed(t.cx))) / (w1 + w2 + w3));
    p.y = pits_pkg::coord_t'((w1 * longint'($signed(t.ay)) + w2 * longint'($signed(t.by))
                              + w3 * longint'($signed(t.cy))) / (w1 + w2 + w3));
    return p;
  endfunction

  // Point on a loaded triangle that some slot below FilledSlots contains, so
  // a long walk stops inside the loaded region; fall back to the origin,
  // which slot 0 covers.
  function automatic pt_t early_hit_point();
    pt_t         p;
    int unsigned i;
    bit          covered;
    p       = point_on(plan_table[$urandom_range(1, FilledSlots - 1)]);
    covered = 1'b0;
    for (i = 0; i < FilledSlots; i++) begin
      if (contains(plan_table[i], p.x, p.y)) covered = 1'b1;
    end
    if (!covered) p = pt_of(0, 0);
    return p;
  endfunction

  function automatic void enqueue_load(int unsigned slot, pits_pkg::tri_t t);
    pits_pkg::pits_cmd_t c;
    c          = random_cmd();
    c.func     = pits_pkg::FuncLoad;
    c.slot     = slot[pits_pkg::SlotBits-1:0];
    c.first_x  = t.ax;
    c.first_y  = t.ay;
    c.second_x = t.bx;
    c.second_y = t.by;
    c.third_x  = t.cx;
    c.third_y  = t.cy;
    plan_table[slot[pits_pkg::SlotBits-1:0]] = t;
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic void enqueue_query(pt_t p);
    pits_pkg::pits_cmd_t c;
    c         = random_cmd();
    c.func    = pits_pkg::FuncQuery;
    c.query_x = p.x;
    c.query_y = p.y;
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold until every queued beat is taken, answered, and the walk is over.
  task automatic wait_drained();
    @(negedge clk_i);
    while (cmd_q.size() != 0 || start || busy || answer_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Write the search count only while the block is idle.
  task automatic set_tri_count(int unsigned value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i        <= 1'b1;
    cfg_wdata_i     <= value[pits_pkg::CountBits-1:0];
    tri_count_model  = value[pits_pkg::CountBits-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Driver: pop pending beats onto cmd_i; predict each beat as it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_cmds
    int unsigned gap;
    if (!rst_ni) begin
      start       <= 1'b0;
      gap_left    <= 0;
      steady_left <= 0;
    end else if (start && !busy) begin
      // Beat taken: the predictor advances in acceptance order.
      answer_q.insert(answer_q.size(), resolve_cmd(cmd_i));
      if (steady_left != 0) begin
        steady_left <= steady_left - 1;
        gap = 0;
      end else begin
        gap = pick_gap();
        // Now and then run a stretch of back-to-back beats.
        if ($urandom_range(0, 99) < 4) steady_left <= $urandom_range(15, 40);
      end
      // Keep start high for the next beat, or drop it for a gap.
      if (gap == 0 && cmd_q.size() != 0) begin
        cmd_i <= cmd_q.pop_front();
      end else begin
        start    <= 1'b0;
        gap_left <= gap;
      end
    end else if (!start) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (cmd_q.size() != 0) begin
        cmd_i <= cmd_q.pop_front();
        start <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every done_o beat must match the oldest predicted answer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_answers
    pits_pkg::pits_result_t want;
    if (rst_ni && done_o) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result found=%0d index=%0d", $time,
                 result_o.found, result_o.triangle_index);
        mismatch_count++;
      end else begin
        want = answer_q.pop_front();
        if (result_o.found !== want.found) begin
          $display("%0t: found mismatch: expected %0d, actual %0d", $time,
                   want.found, result_o.found);
          mismatch_count++;
        end
        if (result_o.triangle_index !== want.triangle_index) begin
          $display("%0t: triangle_index mismatch: expected %0d, actual %0d", $time,
                   want.triangle_index, result_o.triangle_index);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves in either direction for too long.
  // A full-table miss stays well under the limit.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_test
    int unsigned phase, k, r, n, slot;
    pt_t         p;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty search first.
    set_tri_count(0);
    enqueue_query(pt_of(0, 0));

    // Slot 0 collinear, slot 1 a large triangle, slots 2 and 3 split the full
    // coordinate square along its diagonal with opposite windings.
    enqueue_load(0, tri_of(0, 0, 1000, 1000, 2000, 2000));
    enqueue_load(1, tri_of(-Half, -Half, Half, -Half, 0, Half));
    enqueue_load(2, tri_of(CoordMin, CoordMax, CoordMax, CoordMax, CoordMin, CoordMin));
    enqueue_load(3, tri_of(CoordMax, CoordMin, CoordMax, CoordMax, CoordMin, CoordMin));
    enqueue_load(TableDepth - 1, random_tri(23));

    set_tri_count(2);
    enqueue_query(pt_of(1000, 1000));          // on the collinear one, must skip to slot 1
    enqueue_query(pt_of(Half, -Half));         // on a vertex
    enqueue_query(pt_of(0, -Half));            // on an edge
    enqueue_query(pt_of(-8000000, 8000000));   // outside both: miss
    enqueue_query(pt_of(CoordMax, CoordMin));  // extreme corner: miss

    set_tri_count(4);
    enqueue_query(pt_of(-8000000, 8000000));
    enqueue_query(pt_of(CoordMax, CoordMin));
    enqueue_query(pt_of(CoordMax, CoordMax));  // shared vertex, first slot wins
    enqueue_query(pt_of(CoordMin, CoordMax));

    // Fill the small search region before the random phases.
    for (k = 4; k < FilledSlots; k++) enqueue_load(k, random_tri(23));

    // Random phases over small tables.
    for (phase = 0; phase < RandomPhases; phase++) begin
      n = (phase == 0) ? 1 : $urandom_range(0, FilledSlots);
      set_tri_count(n);
      for (k = 0; k < PhaseItems; k++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          slot = ($urandom_range(0, 99) < 70) ? $urandom_range(0, FilledSlots - 1)
                                               : $urandom_range(0, TableDepth - 1);
          enqueue_load(slot, random_tri(($urandom_range(0, 1) != 0) ? 23 : 12));
        end else begin
          r = $urandom_range(0, 99);
          if (n != 0 && r < 70) begin
            p = point_on(plan_table[$urandom_range(0, n - 1)]);
          end else if (r < 85) begin
            // Just off a stored triangle.
            p   = point_on(plan_table[$urandom_range(0, FilledSlots - 1)]);
            p.x = p.x + pits_pkg::coord_t'(jitter(16));
            p.y = p.y + pits_pkg::coord_t'(jitter(16));
          end else begin
            p.x = rand_coord();
            p.y = rand_coord();
          end
          enqueue_query(p);
        end
      end
    end

    // Counts at the depth and past it: slot 0 holds a large triangle around
    // the origin, and every point here is contained in the loaded region.
    enqueue_load(0, tri_of(-Half, -Half, Half, -Half, 0, Half));
    set_tri_count(TableDepth);
    enqueue_query(pt_of(0, 0));
    for (k = 0; k < LongQueries; k++) enqueue_query(early_hit_point());

    set_tri_count(CountMax);
    enqueue_query(pt_of(0, 0));
    for (k = 0; k < LongQueries; k++) enqueue_query(early_hit_point());

    // Drain, then watch a little longer for stray results.
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
